// ===== rtl/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and codes for the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

	// result status codes
	localparam logic [1:0] ST_ALLOC = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FREED = 2'd2;
	localparam logic [1:0] ST_NOJOB = 2'd3;

	// placement policy codes
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	// configuration register indexes
	localparam logic REG_POLICY  = 1'b0;
	localparam logic REG_MEMSIZE = 1'b1;

	// request kinds
	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_TAG,
		S_DONE
	} state_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic shift;   // rotate the ring by one place
		logic tag;     // write job id into the head cell
		logic clear;   // free the head cell if owned by job
	} cell_ctl_t;

endpackage

// ===== rtl/contiguous_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Owner map of memory units held in a rotating ring of cells, with a
// sequencer that finds holes by first, best or worst fit and tags/releases.
// ----------------------------------------------------------------------------
// channel   | signals                                  | direction
// request   | start, busy, kind, job_id, units         | in (busy out)
// result    | done, status, start_unit, units_freed,   | out, one cycle
//           | free_units                               |
// config    | cfg_we, cfg_index, cfg_data              | in
//
// An allocate that finds a hole makes two full ring rotations: one to scan
// the holes, a second to tag the chosen run. An allocate that finds none,
// and a release, make one rotation only.
// The ring rotation length sets how long each of them takes.
// Reset clears the map at once; no clearing pass. done pulses for one
// cycle; the receiver cannot stall, start is taken whenever busy is low.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator #(
	parameter int MEM_UNITS   = 128,
	parameter int JOB_ID_BITS = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       kind,
	input  logic [4:0] job_id,
	input  logic [7:0] units,
	output logic       done,
	output logic [1:0] status,
	output logic [7:0] start_unit,
	output logic [7:0] units_freed,
	output logic [7:0] free_units,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import cfa_pkg::*;

	localparam int IW = $clog2(MEM_UNITS);
	localparam int CW = $clog2(MEM_UNITS + 1);
	localparam int JW = (JOB_ID_BITS < 5) ? JOB_ID_BITS : 5;
	localparam int VW = (CW > 8) ? CW : 8;

	// configuration
	logic [1:0] policy_q;
	logic [7:0] memsize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= POL_FIRST;
			memsize_q <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLICY:  policy_q  <= cfg_data[1:0];
				REG_MEMSIZE: memsize_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// units in use, saturated to the ring size
	logic [CW-1:0] n_use;
	always_comb begin
		if ({24'd0, memsize_q} > MEM_UNITS)
			n_use = CW'(MEM_UNITS);
		else
			n_use = CW'(memsize_q);
	end

	// request registers
	logic                   kind_q;
	logic [JOB_ID_BITS-1:0] job_q;
	logic [7:0]             need_q;
	logic [CW-1:0]          n_q;

	// scan state
	state_t        state_q, state_d;
	logic [IW-1:0] pos_q;        // ring position at the head (unit pos+1)
	logic          last_pos;
	logic [CW-1:0] run_start_q, run_len_q;
	logic [CW-1:0] pick_q, pick_len_q;
	logic [CW-1:0] free_q, freed_q;
	logic [1:0]    st_q;

	// ring of cells
	logic [JOB_ID_BITS-1:0] own [MEM_UNITS];
	logic [JOB_ID_BITS-1:0] head_own;
	cell_ctl_t              ctl;

	// entries move towards cell 0; the last cell takes cell 0's entry
	for (genvar i = 0; i < MEM_UNITS; i++) begin : g_ring
		cfa_cell #(
			.JOB_ID_BITS(JOB_ID_BITS),
			.IS_HEAD    (i == MEM_UNITS - 1)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.job       (job_q),
			.prev_owner(own[(i + 1) % MEM_UNITS]),
			.owner     (own[i])
		);
	end

	// entry about to pass the head: cell 0 holds unit pos_q+1
	assign head_own = own[0];
	assign last_pos = (pos_q == IW'(MEM_UNITS - 1));

	logic          in_use;
	logic          is_free;
	logic [CW-1:0] pos_ext;
	assign pos_ext = CW'(pos_q);
	assign in_use  = pos_ext < n_q;
	assign is_free = (head_own == '0);

	// candidate hole closing at this step
	logic          close_hole;
	logic [CW-1:0] cand_len;
	logic          better;
	logic          run_cont;
	assign run_cont = in_use && is_free;
	assign cand_len = run_len_q + CW'(run_cont);
	// hole ends when this entry is not free or out of use, or at the ring end
	assign close_hole = (run_len_q != '0 && !run_cont) ||
		(run_cont && last_pos);
	always_comb begin
		better = 1'b0;
		if (VW'(need_q) <= VW'(cand_len)) begin
			if (pick_q == '0)
				better = 1'b1;
			else if (policy_q == POL_BEST)
				better = cand_len < pick_len_q;
			else if (policy_q == POL_WORST)
				better = cand_len > pick_len_q;
		end
	end

	logic start_ok;
	assign start_ok = start && !busy;

	// datapath
	logic valid_alloc;
	assign valid_alloc = (job_q != '0) && (need_q != '0);

	// tag window during second rotation
	logic          in_run;
	logic [CW:0]   run_end;
	assign run_end = {1'b0, pick_q} + {1'b0, CW'(need_q)} - 1'b1;
	assign in_run  = ({1'b0, pos_ext} + 1'b1 >= {1'b0, pick_q}) &&
		({1'b0, pos_ext} + 1'b1 <= run_end) && in_use;

	// pick after this scan step is non-zero
	function automatic logic pick_d_nz();
		pick_d_nz = (pick_q != '0) || (valid_alloc && close_hole && better);
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start_ok) state_d = S_SCAN;
			S_SCAN: if (last_pos)
				state_d = (kind_q == KIND_ALLOC && pick_d_nz()) ? S_TAG : S_DONE;
			S_TAG:  if (last_pos) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// cell control
	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_SCAN: begin
				ctl.shift = 1'b1;
				ctl.clear = (kind_q == KIND_RELEASE) && in_use && job_q != '0;
			end
			S_TAG: begin
				ctl.shift = 1'b1;
				ctl.tag   = in_run;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (start_ok) begin
				kind_q      <= kind;
				job_q       <= JOB_ID_BITS'(job_id[JW-1:0]);
				need_q      <= units;
				n_q         <= n_use;
				pos_q       <= '0;
				run_start_q <= '0;
				run_len_q   <= '0;
				pick_q      <= '0;
				pick_len_q  <= '0;
				free_q      <= '0;
				freed_q     <= '0;
			end
			S_SCAN: begin
				pos_q <= last_pos ? '0 : pos_q + 1'b1;
				if (kind_q == KIND_ALLOC) begin
					if (run_cont) begin
						if (run_len_q == '0) run_start_q <= pos_ext + 1'b1;
						run_len_q <= run_len_q + 1'b1;
					end else begin
						run_len_q <= '0;
					end
					if (valid_alloc && close_hole && better) begin
						pick_q     <= (run_len_q == '0) ? pos_ext + 1'b1 : run_start_q;
						pick_len_q <= cand_len;
					end
					free_q <= free_q + CW'(run_cont);
				end else begin
					if (in_use && job_q != '0 && head_own == job_q) begin
						freed_q <= freed_q + 1'b1;
						free_q  <= free_q + 1'b1;
					end else begin
						free_q <= free_q + CW'(run_cont);
					end
				end
				if (last_pos) begin
					if (kind_q == KIND_RELEASE)
						st_q <= (freed_q != '0 ||
							(in_use && job_q != '0 && head_own == job_q))
							? ST_FREED : ST_NOJOB;
					else
						st_q <= pick_d_nz() ? ST_ALLOC : ST_NOFIT;
				end
			end
			S_TAG: begin
				pos_q <= last_pos ? '0 : pos_q + 1'b1;
				if (in_run) free_q <= free_q - 1'b1;
			end
			default: ;
		endcase
	end

	// result
	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_DONE);
	assign status      = st_q;
	assign start_unit  = (st_q == ST_ALLOC) ? 8'(pick_q) : 8'd0;
	assign units_freed = 8'(freed_q);
	assign free_units  = 8'(free_q);

`ifndef NO_ASSERTIONS
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start_ok |=> busy) else $error("start not taken");
	a_tag_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAG |-> kind_q == KIND_ALLOC && pick_q != '0)
		else $error("tag without pick");
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> free_q <= n_q) else $error("free count too big");
`endif
endmodule

// ===== rtl/cfa_cell.sv =====
// ----------------------------------------------------------------------------
// cfa_cell
// One owner entry of the rotating unit ring; takes its neighbour's entry on
// each shift, and the head cell may be tagged or freed on the way through.
// ----------------------------------------------------------------------------
module cfa_cell #(
	parameter int JOB_ID_BITS = 5,
	parameter bit IS_HEAD     = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfa_pkg::cell_ctl_t     ctl,
	input  logic [JOB_ID_BITS-1:0] job,
	input  logic [JOB_ID_BITS-1:0] prev_owner,
	output logic [JOB_ID_BITS-1:0] owner
);
	import cfa_pkg::*;

	logic [JOB_ID_BITS-1:0] owner_q;
	logic [JOB_ID_BITS-1:0] nxt;

	// head cell modifies the entry as it passes in from the tail
	always_comb begin
		nxt = prev_owner;
		if (IS_HEAD) begin
			if (ctl.tag)
				nxt = job;
			else if (ctl.clear && prev_owner == job)
				nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			owner_q <= '0;
		else if (ctl.shift)
			owner_q <= nxt;
	end

	assign owner = owner_q;
endmodule
